// ===== hdl/hysteresis_peak_finder_macros.svh =====
// Assertion macros used by the back part of the peak finder.
`ifndef HYSTERESIS_PEAK_FINDER_MACROS_SVH
`define HYSTERESIS_PEAK_FINDER_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define HPF_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define HPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define HPF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hpf_pkg.sv =====
package hpf_pkg;

    localparam int DEF_MAX_SAMPLES = 128;
    localparam int VAL_W = 32;
    localparam int IDX_W = 7;
    localparam int CNT_W = IDX_W + 1;

    // Write of one extremum entry from the front part into the list memory.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [VAL_W-1:0] val;
        logic [IDX_W-1:0] idx;
    } t_wr;

    // Summary of one loaded sample set, handed to the search.
    typedef struct packed {
        logic [CNT_W-1:0] len;   // entries in the list, endpoint included
        logic [VAL_W-1:0] v0;    // first three list values
        logic [VAL_W-1:0] v1;
        logic [VAL_W-1:0] v2;
        logic [VAL_W-1:0] ev;    // final endpoint value
        logic [IDX_W-1:0] ei;    // final endpoint sample index
        logic [VAL_W-1:0] mmag;  // smallest list value
        logic [VAL_W-1:0] maxv;
        logic [VAL_W-1:0] minv;
    } t_job;

endpackage

// ===== hdl/hpf_if.sv =====
interface hpf_in_if;
    logic                     valid;
    logic                     ready;
    logic [hpf_pkg::VAL_W-1:0] sample;
    logic                     last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface hpf_out_if;
    logic                     valid;
    logic                     ready;
    logic [hpf_pkg::IDX_W-1:0] peak_index;
    logic [hpf_pkg::VAL_W-1:0] peak_value;
    logic                     no_peak;
    logic                     last_result;

    modport source (output valid, output peak_index, output peak_value, output no_peak,
                    output last_result, input ready);
    modport sink (input valid, input peak_index, input peak_value, input no_peak,
                  input last_result, output ready);
endinterface

// ===== hdl/hpf_front.sv =====
module hpf_front #(
    parameter int MAX_SAMPLES = hpf_pkg::DEF_MAX_SAMPLES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hpf_in_if.sink        i_smp,
    output hpf_pkg::t_wr  o_wr,
    output logic          o_push,
    output hpf_pkg::t_job o_job,
    input  logic          i_done
);
    import hpf_pkg::*;

    logic [CNT_W-1:0] r_cnt, r_ecnt;
    logic [VAL_W-1:0] r_max, r_min, r_prev, r_emin, r_v0, r_v1, r_v2;
    logic             r_prev_up, r_hold;

    logic             w_acc, w_stored, w_app, w_last;
    logic [VAL_W-1:0] w_s, w_app_val, w_ev, w_emin, w_max, w_min, w_v0, w_v1, w_v2;
    logic [IDX_W-1:0] w_app_idx, w_ei, w_jm1;
    logic [CNT_W-1:0] w_c2;

    assign i_smp.ready = !r_hold;
    assign w_acc    = i_smp.valid && !r_hold;
    assign w_s      = i_smp.sample;
    assign w_last   = i_smp.last_sample;
    assign w_stored = r_cnt < CNT_W'(MAX_SAMPLES);
    assign w_jm1    = IDX_W'(r_cnt - CNT_W'(1));

    // A sample index j marks an extremum at j-1 when the step direction flips.
    always_comb begin
        w_app     = w_acc && w_stored &&
                    (r_cnt == '0 || (r_cnt >= CNT_W'(2) && ((w_s > r_prev) != r_prev_up)));
        w_app_val = (r_cnt == '0) ? w_s : r_prev;
        w_app_idx = (r_cnt == '0) ? '0 : w_jm1;
        w_c2      = r_ecnt + CNT_W'(w_app);
        w_ev      = w_stored ? w_s : r_prev;
        w_ei      = w_stored ? r_cnt[IDX_W-1:0] : w_jm1;
        w_emin    = (w_app && w_app_val < r_emin) ? w_app_val : r_emin;
        w_max     = (w_stored && w_s > r_max) ? w_s : r_max;
        w_min     = (w_stored && w_s < r_min) ? w_s : r_min;
        w_v0 = r_v0;
        w_v1 = r_v1;
        w_v2 = r_v2;
        if (w_app) begin
            if (r_ecnt == CNT_W'(0)) w_v0 = w_app_val;
            if (r_ecnt == CNT_W'(1)) w_v1 = w_app_val;
            if (r_ecnt == CNT_W'(2)) w_v2 = w_app_val;
        end
        if (w_last) begin
            if (w_c2 == CNT_W'(1)) w_v1 = w_ev;
            if (w_c2 == CNT_W'(2)) w_v2 = w_ev;
        end
    end

    assign o_wr.en   = w_app;
    assign o_wr.addr = r_ecnt[IDX_W-1:0];
    assign o_wr.val  = w_app_val;
    assign o_wr.idx  = w_app_idx;

    assign o_push     = w_acc && w_last;
    assign o_job.len  = w_c2 + CNT_W'(1);
    assign o_job.v0   = w_v0;
    assign o_job.v1   = w_v1;
    assign o_job.v2   = w_v2;
    assign o_job.ev   = w_ev;
    assign o_job.ei   = w_ei;
    assign o_job.mmag = (w_ev < w_emin) ? w_ev : w_emin;
    assign o_job.maxv = w_max;
    assign o_job.minv = w_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_ecnt <= '0;
            r_max  <= '0;
            r_min  <= '1;
            r_emin <= '1;
            r_hold <= 1'b0;
        end else if (w_acc && w_last) begin
            r_cnt  <= '0;
            r_ecnt <= '0;
            r_max  <= '0;
            r_min  <= '1;
            r_emin <= '1;
            r_hold <= 1'b1;
        end else begin
            if (w_acc && w_stored) r_cnt <= r_cnt + CNT_W'(1);
            if (w_acc) begin
                r_ecnt <= w_c2;
                r_max  <= w_max;
                r_min  <= w_min;
                r_emin <= w_emin;
            end
            if (i_done) r_hold <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_stored) begin
            r_prev    <= w_s;
            r_prev_up <= w_s > r_prev;
        end
        if (w_acc) begin
            r_v0 <= w_v0;
            r_v1 <= w_v1;
            r_v2 <= w_v2;
        end
    end

endmodule

// ===== hdl/hpf_job_fifo.sv =====
module hpf_job_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hpf_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_empty,
    output hpf_pkg::t_job o_job
);
    import hpf_pkg::*;

    t_job       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_ent[r_wp] <= i_job;
    end

endmodule

// ===== hdl/hpf_back.sv =====
module hpf_back #(
    parameter int MAX_SAMPLES = hpf_pkg::DEF_MAX_SAMPLES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hpf_pkg::t_wr  i_wr,
    input  logic          i_empty,
    input  hpf_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_done,
    hpf_out_if.source     o_res
);
    import hpf_pkg::*;
    `include "hysteresis_peak_finder_macros.svh"

    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int LIMIT = (MAX_SAMPLES + 1) / 2;
    localparam logic [1:0] SGN_DN = 2'd0, SGN_EQ = 2'd1, SGN_UP = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_SHORT, S_RD, S_PROC, S_FINAL, S_FLUSH
    } t_st;

    function automatic logic [1:0] sgn(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        sgn = (b > a) ? SGN_UP : ((b < a) ? SGN_DN : SGN_EQ);
    endfunction

    logic [VAL_W-1:0] r_mem_v [MAX_SAMPLES];
    logic [IDX_W-1:0] r_mem_i [MAX_SAMPLES];

    t_st              r_st, n_st;
    t_job             r_job;
    logic [VAL_W-3:0] r_sel, n_sel;
    logic             r_del, n_del, r_r, n_r, r_valley, n_valley, r_found, n_found;
    logic             r_hasp, n_hasp, r_isend, r_ov, n_ov;
    logic [CNT_W-1:0] r_len, n_len, r_p, n_p, r_cnt, n_cnt;
    logic [VAL_W-1:0] r_lm, n_lm, r_pk, n_pk, r_pend_v, n_pend_v, r_q_v;
    logic [IDX_W-1:0] r_pki, n_pki, r_pend_i, n_pend_i, r_q_i;
    logic [IDX_W-1:0] r_oi, n_oi;
    logic [VAL_W-1:0] r_ovl, n_ovl;
    logic             r_onp, n_onp, r_olast, n_olast;

    logic [CNT_W-1:0] w_phys;
    logic [VAL_W:0]   w_sel33;
    logic [VAL_W-1:0] w_x, w_pk_eff, w_bv, w_e_v, w_x0, w_x1;
    logic [IDX_W-1:0] w_xi, w_bi, w_e_i;
    logic             w_peak_hit, w_e_req, w_e_take, w_canpush, w_stall, w_push, w_dl;
    logic [1:0]       w_s1, w_s2;

    assign w_phys  = r_p + CNT_W'(r_del && (r_p >= CNT_W'(r_r)));
    assign w_sel33 = {3'b000, r_sel};

    // Candidate evaluation for the element in hand, and what it would emit.
    always_comb begin
        w_x        = r_isend ? r_job.ev : r_q_v;
        w_xi       = r_isend ? r_job.ei : r_q_i;
        w_pk_eff   = r_found ? r_job.mmag : r_pk;
        w_peak_hit = (w_x > w_pk_eff) && ({1'b0, w_x} > {1'b0, r_lm} + w_sel33);
        w_bv       = (r_job.ev > r_job.v0) ? r_job.ev : r_job.v0;
        w_bi       = (r_job.ev > r_job.v0) ? r_job.ei : '0;
        w_e_req    = 1'b0;
        w_e_i      = r_pki;
        w_e_v      = r_pk;
        case (r_st)
            S_PROC: begin
                w_e_req = r_valley && ({1'b0, r_pk} > w_sel33 + {1'b0, w_x});
            end
            S_FINAL: begin
                if (r_job.ev > r_pk && {1'b0, r_job.ev} > {1'b0, r_lm} + w_sel33) begin
                    w_e_req = 1'b1;
                    w_e_i   = r_job.ei;
                    w_e_v   = r_job.ev;
                end else begin
                    w_e_req = !r_found && (r_pk > r_job.mmag);
                end
            end
            S_SHORT: begin
                w_e_req = {1'b0, w_bv} > {1'b0, r_job.mmag} + w_sel33;
                w_e_i   = w_bi;
                w_e_v   = w_bv;
            end
            default: w_e_req = 1'b0;
        endcase
        w_e_take  = w_e_req && (r_cnt < CNT_W'(LIMIT));
        w_canpush = !r_ov || o_res.ready;
        w_stall   = w_e_take && r_hasp && !w_canpush;
    end

    // Ordering checks on the first three list entries.
    always_comb begin
        w_s1 = sgn(r_job.v0, r_job.v1);
        w_s2 = sgn(r_job.v1, r_job.v2);
        w_dl = (r_job.len > CNT_W'(2)) && (w_s1 == w_s2);
        w_x0 = r_job.v0;
        w_x1 = r_job.v1;
        if (w_dl) begin
            w_x0 = (w_s1 == SGN_UP) ? r_job.v1 : r_job.v0;
            w_x1 = r_job.v2;
        end
    end

    always_comb begin
        n_st = r_st;   n_sel = r_sel;   n_del = r_del;     n_r = r_r;
        n_valley = r_valley;            n_found = r_found; n_hasp = r_hasp;
        n_len = r_len; n_p = r_p;       n_cnt = r_cnt;     n_lm = r_lm;
        n_pk = r_pk;   n_pki = r_pki;   n_pend_v = r_pend_v;
        n_pend_i = r_pend_i;
        o_pop  = 1'b0;
        o_done = 1'b0;
        w_push = 1'b0;
        n_oi = r_oi; n_ovl = r_ovl; n_onp = r_onp; n_olast = r_olast;

        case (r_st)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_st  = S_SETUP;
                end
            end
            S_SETUP: begin
                n_sel    = (VAL_W-2)'((r_job.maxv - r_job.minv) >> 2);
                n_del    = w_dl;
                n_r      = (w_s1 != SGN_UP);
                n_len    = r_job.len - CNT_W'(w_dl);
                n_p      = (w_x0 >= w_x1) ? '0 : CNT_W'(1);
                n_lm     = r_job.mmag;
                n_pk     = r_job.mmag;
                n_pki    = '0;
                n_found  = 1'b0;
                n_valley = 1'b0;
                n_hasp   = 1'b0;
                n_cnt    = '0;
                n_st     = (r_job.len == CNT_W'(2)) ? S_SHORT : S_RD;
            end
            S_RD: n_st = S_PROC;
            S_PROC: begin
                if (!r_valley) begin
                    if (r_found) begin
                        n_pk    = r_job.mmag;
                        n_found = 1'b0;
                    end
                    if (w_peak_hit) begin
                        n_pk  = w_x;
                        n_pki = w_xi;
                    end
                    if (r_p == r_len - CNT_W'(1)) begin
                        n_st = S_FINAL;
                    end else begin
                        n_p      = r_p + CNT_W'(1);
                        n_valley = 1'b1;
                        n_st     = S_RD;
                    end
                end else if (!w_stall) begin
                    if (w_e_req) begin
                        n_found = 1'b1;
                        n_lm    = w_x;
                    end else if (w_x < r_lm) begin
                        n_lm = w_x;
                    end
                    n_p      = r_p + CNT_W'(1);
                    n_valley = 1'b0;
                    n_st     = (r_p + CNT_W'(1) < r_len) ? S_RD : S_FINAL;
                end
            end
            S_FINAL, S_SHORT: begin
                if (!w_stall) n_st = S_FLUSH;
            end
            S_FLUSH: begin
                if (w_canpush) begin
                    w_push  = 1'b1;
                    n_oi    = r_hasp ? r_pend_i : '0;
                    n_ovl   = r_hasp ? r_pend_v : '0;
                    n_onp   = !r_hasp;
                    n_olast = 1'b1;
                    o_done  = 1'b1;
                    n_st    = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase

        // A new peak displaces the held one, which then goes out as non-final.
        if (w_e_take && !w_stall) begin
            if (r_hasp) begin
                w_push  = 1'b1;
                n_oi    = r_pend_i;
                n_ovl   = r_pend_v;
                n_onp   = 1'b0;
                n_olast = 1'b0;
            end
            n_pend_i = w_e_i;
            n_pend_v = w_e_v;
            n_hasp   = 1'b1;
            n_cnt    = r_cnt + CNT_W'(1);
        end

        n_ov = w_push || (r_ov && !o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_ov  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_st  <= n_st;
            r_ov  <= n_ov;
            r_cnt <= n_cnt;
        end
        if (o_pop) r_job <= i_job;
        r_sel <= n_sel;   r_del <= n_del;     r_r <= n_r;
        r_valley <= n_valley;                 r_found <= n_found;
        r_hasp <= n_hasp; r_len <= n_len;     r_p <= n_p;
        r_lm <= n_lm;     r_pk <= n_pk;
        r_pki <= n_pki;   r_pend_v <= n_pend_v;
        r_pend_i <= n_pend_i;
        r_oi <= n_oi;     r_ovl <= n_ovl;     r_onp <= n_onp;
        r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_v[i_wr.addr[AW-1:0]] <= i_wr.val;
            r_mem_i[i_wr.addr[AW-1:0]] <= i_wr.idx;
        end
        if (r_st == S_RD) begin
            r_q_v   <= r_mem_v[w_phys[AW-1:0]];
            r_q_i   <= r_mem_i[w_phys[AW-1:0]];
            r_isend <= (w_phys == r_job.len - CNT_W'(1));
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.peak_index  = r_oi;
    assign o_res.peak_value  = r_ovl;
    assign o_res.no_peak     = r_onp;
    assign o_res.last_result = r_olast;

    `HPF_ASSERT(a_cnt_cap, r_cnt <= CNT_W'(LIMIT), "result count above limit")
    `HPF_ASSERT_NXT(a_rd_proc, r_st == S_RD, r_st == S_PROC, "read not followed by process")
    `HPF_ASSERT_IMP(a_no_overwrite, w_push, !r_ov || o_res.ready, "result overwritten")

endmodule

// ===== hdl/hysteresis_peak_finder.sv =====
// Channel   Dir  Payload                                          Transaction
// i_smp     in   sample[31:0], last_sample                        one sample
// o_res     out  peak_index[6:0], peak_value[31:0], no_peak,      one result
//                last_result
//
// Samples load at one per cycle while the input is not stalled; extrema are found on the fly as they arrive.
// After the last sample the search walks the list through the single read port of the extremum list memory.
// The input stalls from the last sample until the final result is registered.
// Reset is synchronous and active low; no clearing pass is needed after it.
// A stalled output holds the search until the result register drains.
module hysteresis_peak_finder #(
    parameter int MAX_SAMPLES = hpf_pkg::DEF_MAX_SAMPLES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hpf_in_if.sink    i_smp,
    hpf_out_if.source o_res
);
    import hpf_pkg::*;

    // The front part stores each sample's contribution to the extremum list
    // and summarizes the set; the back part walks the list with hysteresis.
    t_wr  w_wr;
    t_job w_job_in, w_job_out;
    logic w_push, w_pop, w_empty, w_done;

    hpf_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (i_smp),
        .o_wr    (w_wr),
        .o_push  (w_push),
        .o_job   (w_job_in),
        .i_done  (w_done)
    );

    // A short queue of set summaries decouples the two parts.
    hpf_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_job_out)
    );

    hpf_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_empty (w_empty),
        .i_job   (w_job_out),
        .o_pop   (w_pop),
        .o_done  (w_done),
        .o_res   (o_res)
    );

endmodule
